// ===== rtl/ipu_pkg.sv =====
// Shared types and constants for the integer pixel upscaler.
// No dependencies; used by rtl/integer_pixel_upscaler.sv.
package ipu_pkg;

   localparam int SCALE_BITS  = 7;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam int ROW_BITS    = 12;
   localparam int PAD_BITS    = 2;
   localparam int PIXEL_BITS  = 24;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT = 13'd4096;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCALE      = 2'd0,
      CSR_SRC_WIDTH  = 2'd1,
      CSR_SRC_HEIGHT = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic is_pad;
      logic pixel;
      logic row_end;
      logic image_end;
      logic out_of_turn;
   } rsp_flags_type;

endpackage

// ===== rtl/integer_pixel_upscaler.sv =====
// Integer nearest-neighbor upscaler, top level: line buffer, counters, result pipe.
// Depends on rtl/ipu_pkg.sv.
// A result is registered in the stage register and then in the output register.
// Throughput: one request per cycle while the result pipe is not stalled; the line
// buffer read is registered and the result sits in an output register behind a one-entry stage.
// Reset clears the phase, all counters and the pipe valid bits, and sets the configuration
// registers to 1; the line buffer is not cleared.
module integer_pixel_upscaler #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [7:0]                         req_blue,
   input  logic [7:0]                         req_green,
   input  logic [7:0]                         req_red,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_is_pad,
   output logic [7:0]                         rsp_out_blue,
   output logic [7:0]                         rsp_out_green,
   output logic [7:0]                         rsp_out_red,
   output logic                               rsp_row_end,
   output logic                               rsp_image_end,
   output logic                               rsp_out_of_turn,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ipu_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ipu_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = (CW > ipu_pkg::WIDTH_BITS) ? CW : ipu_pkg::WIDTH_BITS;
   localparam int SB = ipu_pkg::SCALE_BITS;
   localparam int HB = ipu_pkg::HEIGHT_BITS;
   localparam int RB = ipu_pkg::ROW_BITS;
   localparam int PB = ipu_pkg::PAD_BITS;

   // configuration
   logic [SB-1:0]                   scale_ff;
   logic [ipu_pkg::WIDTH_BITS-1:0]  src_width_ff;
   logic [HB-1:0]                   src_height_ff;

   // sequencing state
   logic          emitting_ff, emitting_in;
   logic [CW-1:0] load_column_ff, load_column_in;
   logic [RB-1:0] source_row_ff, source_row_in;
   logic [CW-1:0] source_column_ff, source_column_in;
   logic [SB-1:0] column_repeat_ff, column_repeat_in;
   logic [SB-1:0] row_repeat_ff, row_repeat_in;
   logic [PB-1:0] pad_count_ff, pad_count_in;

   // line buffer and result pipe
   logic [ipu_pkg::PIXEL_BITS-1:0] line_buffer [MAX_WIDTH];
   logic [ipu_pkg::PIXEL_BITS-1:0] rdata_ff;
   logic                           s1_valid_ff, s1_valid_in;
   ipu_pkg::rsp_flags_type         s1_flags_ff, s1_flags_in;
   logic                           rsp_valid_ff;
   ipu_pkg::rsp_flags_type         rsp_flags_ff;
   logic [ipu_pkg::PIXEL_BITS-1:0] rsp_pixel_ff;

   // derived bounds
   logic [SB-1:0] n;
   logic [WW-1:0] w_raw;
   logic [CW-1:0] w;
   logic [HB-1:0] h;
   logic [PB-1:0] pad;

   logic          req_accept;
   logic          out_free;
   logic          s1_free;
   logic          wr_en, rd_en, produce, row_done;
   logic [CW:0]   load_sum, col_next;
   logic [SB:0]   col_sum, row_sum;
   logic [PB:0]   pad_sum;
   logic [RB:0]   row_next;

   always_comb begin
      if (scale_ff == '0) begin
         n = SB'(1);
      end else if (scale_ff > SB'(MAX_SCALE)) begin
         n = SB'(MAX_SCALE);
      end else begin
         n = scale_ff;
      end
      w_raw = WW'(src_width_ff);
      if (w_raw == '0) begin
         w = CW'(1);
      end else if (w_raw > WW'(MAX_WIDTH)) begin
         w = CW'(MAX_WIDTH);
      end else begin
         w = w_raw[CW-1:0];
      end
      if (src_height_ff == '0) begin
         h = HB'(1);
      end else if (src_height_ff > ipu_pkg::MAX_HEIGHT) begin
         h = ipu_pkg::MAX_HEIGHT;
      end else begin
         h = src_height_ff;
      end
      pad = PB'(n[PB-1:0] * w[PB-1:0]);
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && s1_free;
   assign csr_ready  = 1'b1;

   always_comb begin
      emitting_in      = emitting_ff;
      load_column_in   = load_column_ff;
      source_row_in    = source_row_ff;
      source_column_in = source_column_ff;
      column_repeat_in = column_repeat_ff;
      row_repeat_in    = row_repeat_ff;
      pad_count_in     = pad_count_ff;
      s1_flags_in      = '0;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      produce          = 1'b0;
      row_done         = 1'b0;
      load_sum         = {1'b0, load_column_ff} + (CW+1)'(1);
      col_sum          = {1'b0, column_repeat_ff} + (SB+1)'(1);
      col_next         = {1'b0, source_column_ff};
      pad_sum          = {1'b0, pad_count_ff} + (PB+1)'(1);
      row_sum          = {1'b0, row_repeat_ff} + (SB+1)'(1);
      row_next         = {1'b0, source_row_ff} + (RB+1)'(1);
      if (req_accept) begin
         if (req_kind == ipu_pkg::KIND_LOAD) begin
            if (emitting_ff) begin
               produce                 = 1'b1;
               s1_flags_in.out_of_turn = 1'b1;
            end else begin
               wr_en = load_column_ff < CW'(MAX_WIDTH);
               if (load_sum >= {1'b0, w}) begin
                  load_column_in   = '0;
                  emitting_in      = 1'b1;
                  source_column_in = '0;
                  column_repeat_in = '0;
                  row_repeat_in    = '0;
                  pad_count_in     = '0;
               end else begin
                  load_column_in = load_sum[CW-1:0];
               end
            end
         end else if (!emitting_ff) begin
            produce                 = 1'b1;
            s1_flags_in.out_of_turn = 1'b1;
         end else begin
            produce = 1'b1;
            if (source_column_ff < w) begin
               rd_en             = 1'b1;
               s1_flags_in.pixel = 1'b1;
               if (col_sum >= {1'b0, n}) begin
                  column_repeat_in = '0;
                  col_next         = {1'b0, source_column_ff} + (CW+1)'(1);
               end else begin
                  column_repeat_in = col_sum[SB-1:0];
               end
               source_column_in = col_next[CW-1:0];
               row_done         = (col_next >= {1'b0, w}) && (pad == '0);
            end else begin
               s1_flags_in.is_pad = 1'b1;
               pad_count_in       = pad_sum[PB-1:0];
               row_done           = pad_sum >= {1'b0, pad};
            end
            if (row_done) begin
               s1_flags_in.row_end = 1'b1;
               source_column_in    = '0;
               column_repeat_in    = '0;
               pad_count_in        = '0;
               if (row_sum >= {1'b0, n}) begin
                  row_repeat_in  = '0;
                  emitting_in    = 1'b0;
                  load_column_in = '0;
                  if (HB'(row_next) >= h) begin
                     s1_flags_in.image_end = 1'b1;
                     source_row_in         = '0;
                  end else begin
                     source_row_in = row_next[RB-1:0];
                  end
               end else begin
                  row_repeat_in = row_sum[SB-1:0];
               end
            end
         end
      end
      s1_valid_in = produce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SB'(1);
         src_width_ff  <= ipu_pkg::WIDTH_BITS'(1);
         src_height_ff <= HB'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (ipu_pkg::csr_index_type'(csr_index))
            ipu_pkg::CSR_SCALE:      scale_ff      <= csr_wdata[SB-1:0];
            ipu_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[ipu_pkg::WIDTH_BITS-1:0];
            ipu_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[HB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitting_ff      <= 1'b0;
         load_column_ff   <= '0;
         source_row_ff    <= '0;
         source_column_ff <= '0;
         column_repeat_ff <= '0;
         row_repeat_ff    <= '0;
         pad_count_ff     <= '0;
      end else begin
         emitting_ff      <= emitting_in;
         load_column_ff   <= load_column_in;
         source_row_ff    <= source_row_in;
         source_column_ff <= source_column_in;
         column_repeat_ff <= column_repeat_in;
         row_repeat_ff    <= row_repeat_in;
         pad_count_ff     <= pad_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_buffer[load_column_ff[AW-1:0]] <= {req_red, req_green, req_blue};
      end
      if (rd_en) begin
         rdata_ff <= line_buffer[source_column_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_flags_ff <= s1_flags_in;
      end
      if (out_free) begin
         rsp_flags_ff <= s1_flags_ff;
         rsp_pixel_ff <= rdata_ff & {ipu_pkg::PIXEL_BITS{s1_flags_ff.pixel}};
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_pad      = rsp_flags_ff.is_pad;
   assign rsp_out_blue    = rsp_pixel_ff[7:0];
   assign rsp_out_green   = rsp_pixel_ff[15:8];
   assign rsp_out_red     = rsp_pixel_ff[23:16];
   assign rsp_row_end     = rsp_flags_ff.row_end;
   assign rsp_image_end   = rsp_flags_ff.image_end;
   assign rsp_out_of_turn = rsp_flags_ff.out_of_turn;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with room in the result pipe");

   a_reject_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_turn |-> !rsp_is_pad && !rsp_row_end && !rsp_image_end
         && rsp_out_blue == 8'd0 && rsp_out_green == 8'd0 && rsp_out_red == 8'd0)
      else $error("rejected transfer carries data or flags");

   a_pad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_pad |-> rsp_out_blue == 8'd0 && rsp_out_green == 8'd0
         && rsp_out_red == 8'd0)
      else $error("pad byte carries pixel data");

   a_image_end_ends_row: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_flags_ff.image_end |-> s1_flags_ff.row_end && !emitting_ff)
      else $error("image end without row end or phase change");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == ipu_pkg::KIND_LOAD && !emitting_ff |=> !s1_valid_ff)
      else $error("accepted load produced a result");
`endif

endmodule
